// File: rtl/core/cdp_pkg.sv
package cdp_pkg;

  // Largest datagram the parser tracks; longer lengths saturate to this
  localparam int unsigned MAX_DATAGRAM_BYTES = 65535;

  // Entries in the queue between the parser and the output stage
  localparam int unsigned QUEUE_DEPTH = 2;

  // Opcodes and verdict codes
  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_TEXT    = 2'd1;
  localparam logic [1:0] KIND_BYE     = 2'd2;

  localparam logic [7:0] OPC_TEXT = 8'd1;
  localparam logic [7:0] OPC_BYE  = 8'd2;

  // Byte roles
  localparam logic [1:0] ROLE_HEADER = 2'd0;
  localparam logic [1:0] ROLE_NAME   = 2'd1;
  localparam logic [1:0] ROLE_TEXT   = 2'd2;

  // Parse phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_NLEN     = 8'b0000_0010,
    PH_NAME     = 8'b0000_0100,
    PH_THI      = 8'b0000_1000,
    PH_TLO      = 8'b0001_0000,
    PH_TEXT     = 8'b0010_0000,
    PH_BYE_NAME = 8'b0100_0000,
    PH_SKIP     = 8'b1000_0000
  } cdp_phase_e;

  // Classified word handed from the parser to the output stage
  typedef struct packed {
    logic [1:0]  role;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  kind;
    logic        hdr_err;
    logic [7:0]  name_cnt;
    logic [15:0] text_cnt;
  } cdp_item_t;

endpackage

// File: rtl/core/cdp_in_if.sv
interface cdp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] datagram_length;

  modport source (
    output valid, data_byte, first_byte, datagram_length,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_byte, datagram_length,
    output ready
  );
endinterface

// File: rtl/core/cdp_out_if.sv
interface cdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic [7:0]  payload_byte;
  logic        end_of_datagram;
  logic [1:0]  verdict;
  logic [7:0]  name_length;
  logic [15:0] text_length;

  modport source (
    output valid, byte_role, payload_byte, end_of_datagram, verdict, name_length,
           text_length,
    input  ready
  );
  modport sink (
    input  valid, byte_role, payload_byte, end_of_datagram, verdict, name_length,
           text_length,
    output ready
  );
endinterface

// File: rtl/core/cdp_front.sv
module cdp_front #(
  parameter int unsigned MaxDatagramBytes = cdp_pkg::MAX_DATAGRAM_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cdp_in_if.sink              in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output cdp_pkg::cdp_item_t  push_item_o
);
  import cdp_pkg::*;

  localparam logic [15:0] MaxLen = 16'(MaxDatagramBytes);

  cdp_phase_e  phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] total_q, total_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  ncnt_q, ncnt_d;
  logic [15:0] tcnt_q, tcnt_d;
  logic        err_q, err_d;

  logic        accept;
  logic        stray;
  logic [15:0] len_lo;
  logic [15:0] len_eff;
  logic [15:0] pos_inc;
  logic [15:0] t_full;
  logic [15:0] bye_cnt;
  logic        nlen_bad;
  logic        name_done;
  logic        tlo_bad;
  logic        text_done;
  logic        bye_done;
  logic        last;
  logic [1:0]  role;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  // Clamp the sampled length
  assign len_lo  = (in_i.datagram_length == 16'd0) ? 16'd1 : in_i.datagram_length;
  assign len_eff = (len_lo > MaxLen) ? MaxLen : len_lo;
  assign bye_cnt = len_eff - 16'd1;

  // Header and span checks for the current byte
  assign pos_inc   = pos_q + 16'd1;
  assign t_full    = {tcnt_q[15:8], in_i.data_byte};
  assign nlen_bad  = ({1'b0, total_q} - 17'd2) < ({9'd0, in_i.data_byte} + 17'd2);
  assign name_done = {1'b0, pos_inc} >= ({9'd0, ncnt_q} + 17'd1);
  assign tlo_bad   = ({2'd0, total_q} - 18'd4 - {10'd0, ncnt_q}) < {2'd0, t_full};
  assign text_done = {2'd0, pos_inc} >= ({10'd0, ncnt_q} + 18'd3 + {2'd0, tcnt_q});
  assign bye_done  = pos_inc >= {8'd0, ncnt_q};

  assign stray = !in_i.first_byte && (phase_q == PH_IDLE);

  // Advance the parse state for one word
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    total_d = total_q;
    kind_d  = kind_q;
    ncnt_d  = ncnt_q;
    tcnt_d  = tcnt_q;
    err_d   = err_q;
    role    = ROLE_HEADER;

    if (in_i.first_byte) begin
      total_d = len_eff;
      pos_d   = 16'd0;
      kind_d  = KIND_INVALID;
      ncnt_d  = 8'd0;
      tcnt_d  = 16'd0;
      err_d   = 1'b0;
      if (len_eff < 16'd2) begin
        err_d   = 1'b1;
        phase_d = PH_SKIP;
      end else if (in_i.data_byte == OPC_TEXT) begin
        kind_d  = KIND_TEXT;
        phase_d = PH_NLEN;
      end else if (in_i.data_byte == OPC_BYE) begin
        kind_d  = KIND_BYE;
        ncnt_d  = bye_cnt[7:0];
        phase_d = (bye_cnt[7:0] != 8'd0) ? PH_BYE_NAME : PH_SKIP;
      end else begin
        err_d   = 1'b1;
        phase_d = PH_SKIP;
      end
    end else if (!stray) begin
      pos_d = pos_inc;
      unique case (phase_q)
        PH_NLEN: begin
          ncnt_d = in_i.data_byte;
          if (nlen_bad) begin
            err_d   = 1'b1;
            phase_d = PH_SKIP;
          end else begin
            phase_d = (in_i.data_byte != 8'd0) ? PH_NAME : PH_THI;
          end
        end
        PH_NAME: begin
          role = ROLE_NAME;
          if (name_done) phase_d = PH_THI;
        end
        PH_THI: begin
          tcnt_d  = {in_i.data_byte, 8'd0};
          phase_d = PH_TLO;
        end
        PH_TLO: begin
          tcnt_d = t_full;
          if (tlo_bad) begin
            err_d   = 1'b1;
            phase_d = PH_SKIP;
          end else begin
            phase_d = (t_full != 16'd0) ? PH_TEXT : PH_SKIP;
          end
        end
        PH_TEXT: begin
          role = ROLE_TEXT;
          if (text_done) phase_d = PH_SKIP;
        end
        PH_BYE_NAME: begin
          role = ROLE_NAME;
          if (bye_done) phase_d = PH_SKIP;
        end
        default: begin
        end
      endcase
    end

    // Close the datagram on its last word
    last = !stray && (({1'b0, pos_d} + 17'd1) >= {1'b0, total_d});
    if (last) phase_d = PH_IDLE;
  end

  // Hand the classified word to the queue
  always_comb begin
    push_item_o.role     = role;
    push_item_o.data     = in_i.data_byte;
    push_item_o.last     = last;
    push_item_o.kind     = kind_d;
    push_item_o.hdr_err  = err_d;
    push_item_o.name_cnt = ncnt_d;
    push_item_o.text_cnt = tcnt_d;
  end

  // Hold state until a word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= 16'd0;
      total_q <= 16'd0;
      kind_q  <= KIND_INVALID;
      ncnt_q  <= 8'd0;
      tcnt_q  <= 16'd0;
      err_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      total_q <= total_d;
      kind_q  <= kind_d;
      ncnt_q  <= ncnt_d;
      tcnt_q  <= tcnt_d;
      err_q   <= err_d;
    end
  end

endmodule

// File: rtl/core/cdp_queue.sv
module cdp_queue #(
  parameter int unsigned Depth = cdp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  cdp_pkg::cdp_item_t  push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output cdp_pkg::cdp_item_t  pop_item_o
);
  import cdp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cdp_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Wrap pointers at the queue depth
  assign wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;

  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  // Store words
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_d;
      if (pop)  rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

// File: rtl/core/cdp_back.sv
module cdp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  cdp_pkg::cdp_item_t  q_item_i,
  cdp_out_if.source           out_o
);
  import cdp_pkg::*;

  logic        valid_q;
  logic        load;
  logic [1:0]  role_q;
  logic [7:0]  data_q;
  logic        last_q;
  logic [1:0]  verdict_q, verdict_d;
  logic [7:0]  nlen_q, nlen_d;
  logic [15:0] tlen_q, tlen_d;

  assign load    = q_valid_i && (!valid_q || out_o.ready);
  assign q_pop_o = load;

  // Report verdict and lengths only on the last word
  always_comb begin
    verdict_d = KIND_INVALID;
    nlen_d    = 8'd0;
    tlen_d    = 16'd0;
    if (q_item_i.last) begin
      verdict_d = q_item_i.hdr_err ? KIND_INVALID : q_item_i.kind;
      nlen_d    = q_item_i.name_cnt;
      tlen_d    = q_item_i.text_cnt;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      role_q    <= q_item_i.role;
      data_q    <= q_item_i.data;
      last_q    <= q_item_i.last;
      verdict_q <= verdict_d;
      nlen_q    <= nlen_d;
      tlen_q    <= tlen_d;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.byte_role       = role_q;
  assign out_o.payload_byte    = data_q;
  assign out_o.end_of_datagram = last_q;
  assign out_o.verdict         = verdict_q;
  assign out_o.name_length     = nlen_q;
  assign out_o.text_length     = tlen_q;

endmodule

// File: rtl/core/chat_datagram_parser_unit.sv
// A word accepted at the input is written into the queue, then loaded into the output
// register, which drives the output.
// Throughput: one word per cycle while the queue has room; the parser state updates in the accept cycle.
// The queue and output register absorb three words while the output stalls;
// once full, input resumes in the cycle after the output takes a word.
// Reset (rst_ni low, asynchronous): parser idle, queue empty, output invalid.
module chat_datagram_parser_unit #(
  parameter int unsigned MaxDatagramBytes = cdp_pkg::MAX_DATAGRAM_BYTES,
  parameter int unsigned QueueDepth       = cdp_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdp_in_if.sink    in_i,
  cdp_out_if.source out_o
);
  import cdp_pkg::*;

  logic      push_valid;
  logic      push_ready;
  cdp_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  cdp_item_t pop_item;

  // Parse and classify bytes
  cdp_front #(
    .MaxDatagramBytes (MaxDatagramBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Decouple parser from output
  cdp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Format and drive results
  cdp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_pop_o   (pop_ready),
    .q_item_i  (pop_item),
    .out_o     (out_o)
  );

endmodule
